/* design/lkv_pkg.sv */
// Shared constants and types for the LRU key-value cache.
// No dependencies; imported by lkv_scan, the top level and the checker.
package lkv_pkg;

  localparam int unsigned LKV_MAX_ENTRIES = 16;
  localparam int unsigned KEY_W           = 32;
  localparam int unsigned VAL_W           = 31;
  localparam int unsigned CAP_W           = 5;

  localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [31:0]      MISS_VALUE = 32'hFFFF_FFFF;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } lkv_cmd_e;

  // Age update left over from the previous request, applied during the next scan.
  typedef struct packed {
    logic vld;
    logic age_all;
  } lkv_pend_t;

  // What the scan found among the entries.
  typedef struct packed {
    logic found;
    logic lru_any;
    logic free_any;
  } lkv_flags_t;

endpackage

/* design/lkv_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
// Depends on nothing; used for the key/value store and the age ranks.
module lkv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/lkv_scan.sv */
// Scan datapath: applies the pending age update to each entry read back and
// tracks the key match, the least recent entry and the first free slot.
// Depends on lkv_pkg.
module lkv_scan
  import lkv_pkg::*;
#(
  parameter int unsigned IdxW  = 4,
  parameter int unsigned RankW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  logic             proc_vld_i,
  input  logic [IdxW-1:0]  proc_idx_i,
  input  logic             entry_vld_i,
  input  logic [KEY_W-1:0] entry_key_i,
  input  logic [VAL_W-1:0] entry_val_i,
  input  logic [RankW-1:0] entry_rank_i,
  input  logic [KEY_W-1:0] req_key_i,
  input  lkv_pend_t        pend_i,
  input  logic [IdxW-1:0]  pend_slot_i,
  input  logic [RankW-1:0] pend_rank_i,
  output logic             rank_we_o,
  output logic [RankW-1:0] rank_wdata_o,
  output lkv_flags_t       flags_o,
  output logic [IdxW-1:0]  found_idx_o,
  output logic [RankW-1:0] found_rank_o,
  output logic [VAL_W-1:0] found_val_o,
  output logic [IdxW-1:0]  lru_idx_o,
  output logic [IdxW-1:0]  free_idx_o
);

  logic [RankW-1:0] rank_upd;
  logic             match;
  lkv_flags_t       flags_q;
  logic [IdxW-1:0]  found_idx_q, lru_idx_q, free_idx_q;
  logic [RankW-1:0] found_rank_q, lru_rank_q;
  logic [VAL_W-1:0] found_val_q;

  // The promoted slot becomes the youngest; valid entries younger than its
  // old rank (or every other valid entry after an insert or an eviction) age by one.
  always_comb begin
    rank_upd = entry_rank_i;
    if (pend_i.vld) begin
      if (proc_idx_i == pend_slot_i) begin
        rank_upd = '0;
      end else if (entry_vld_i && (pend_i.age_all || (entry_rank_i < pend_rank_i))) begin
        rank_upd = entry_rank_i + 1'b1;
      end
    end
  end

  assign match = entry_vld_i && (entry_key_i == req_key_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (clear_i) begin
      flags_q <= '0;
    end else if (proc_vld_i) begin
      if (match && !flags_q.found) begin
        flags_q.found <= 1'b1;
        found_idx_q   <= proc_idx_i;
        found_rank_q  <= rank_upd;
        found_val_q   <= entry_val_i;
      end
      if (entry_vld_i && (!flags_q.lru_any || (rank_upd > lru_rank_q))) begin
        flags_q.lru_any <= 1'b1;
        lru_idx_q       <= proc_idx_i;
        lru_rank_q      <= rank_upd;
      end
      if (!entry_vld_i && !flags_q.free_any) begin
        flags_q.free_any <= 1'b1;
        free_idx_q       <= proc_idx_i;
      end
    end
  end

  assign rank_we_o    = proc_vld_i;
  assign rank_wdata_o = rank_upd;
  assign flags_o      = flags_q;
  assign found_idx_o  = found_idx_q;
  assign found_rank_o = found_rank_q;
  assign found_val_o  = found_val_q;
  assign lru_idx_o    = lru_idx_q;
  assign free_idx_o   = free_idx_q;

endmodule

/* design/lru_key_value_cache.sv */
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg, lkv_ram and lkv_scan.
//
// A request is taken when start is high and busy is low; it is a get or a put
// on a 32-bit key. Every request gives exactly one result, shown on hit_o,
// read_value_o and evicted_o for a single cycle while done_o is high; the
// receiver cannot stall it, so it must take the result in that cycle. A
// request scans the entry memory, whose single read port delivers one entry
// per cycle; after the last read returns, the finish state decides, writes
// back and registers the result. The result strobe comes in the same cycle
// that busy drops, so a new request can be accepted with it. The store is
// empty after reset with no clearing pass: valid bits are flip-flops.
// The capacity register may be written through the configuration channel,
// which is always ready; write it only while no request is in flight.
module lru_key_value_cache
  import lkv_pkg::*;
#(
  parameter int unsigned MaxEntries = LKV_MAX_ENTRIES
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic                     command_i,
  input  logic signed [KEY_W-1:0]  lookup_key_i,
  input  logic        [VAL_W-1:0]  store_value_i,
  output logic                     done_o,
  output logic                     hit_o,
  output logic signed [31:0]       read_value_o,
  output logic                     evicted_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic        [CAP_W-1:0]  cfg_data_i
);

  localparam int unsigned IdxW  = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned RankW = IdxW;
  localparam int unsigned CntW  = $clog2(MaxEntries + 1);
  localparam int unsigned KvW   = KEY_W + VAL_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e           state_q;
  logic [CntW-1:0]  cnt_q;
  logic             proc_vld_q;
  logic [IdxW-1:0]  proc_idx_q;
  lkv_cmd_e         req_cmd_q;
  logic [KEY_W-1:0] req_key_q;
  logic [VAL_W-1:0] req_val_q;
  logic [CAP_W-1:0] cap_q;
  logic [MaxEntries-1:0] valid_q;
  logic [CntW-1:0]  fill_q;
  lkv_pend_t        pend_q;
  logic [IdxW-1:0]  pend_slot_q;
  logic [RankW-1:0] pend_rank_q;
  logic             done_q, hit_q, ev_q;
  logic [31:0]      rdv_q;

  logic             accept;
  logic             scan_issue;
  logic             scan_last;
  logic [KvW-1:0]   kv_rdata;
  logic [RankW-1:0] rank_rdata;
  logic             rank_we;
  logic [RankW-1:0] rank_wdata;
  lkv_flags_t       flags;
  logic [IdxW-1:0]  found_idx, lru_idx, free_idx;
  logic [RankW-1:0] found_rank;
  logic [VAL_W-1:0] found_val;
  logic [31:0]      cap_ext, eff_cap;
  logic             is_put, full, evict_d, insert_d;
  logic [IdxW-1:0]  ins_slot_d, wr_slot_d;
  logic             kv_we;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // Reads are issued for entries 0 .. MaxEntries-1; the data of each comes
  // back in the next cycle and is handled by the scan datapath.
  assign scan_issue = (state_q == ST_SCAN) && (cnt_q != CntW'(MaxEntries));
  assign scan_last  = (state_q == ST_SCAN) && (cnt_q == CntW'(MaxEntries));

  // A capacity of zero acts as one; anything above the store size saturates.
  assign cap_ext = 32'(cap_q);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = 32'd1;
    end else if (cap_ext > 32'(MaxEntries)) begin
      eff_cap = 32'(MaxEntries);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Decision at the end of the scan.
  assign is_put     = (req_cmd_q == CMD_PUT);
  assign full       = (32'(fill_q) >= eff_cap);
  assign evict_d    = is_put && !flags.found && full && flags.lru_any;
  assign insert_d   = is_put && !flags.found && !full && flags.free_any;
  assign ins_slot_d = evict_d ? lru_idx : free_idx;
  assign wr_slot_d  = flags.found ? found_idx : ins_slot_d;
  assign kv_we      = (state_q == ST_FINISH) && is_put &&
                      (flags.found || evict_d || insert_d);

  lkv_ram #(
    .Width (KvW),
    .Depth (MaxEntries),
    .AddrW (IdxW)
  ) u_kv_ram (
    .clk_i   (clk_i),
    .we_i    (kv_we),
    .waddr_i (wr_slot_d),
    .wdata_i ({req_key_q, req_val_q}),
    .re_i    (scan_issue),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (kv_rdata)
  );

  // Ranks are written back in the cycle their read data returns, one address
  // behind the read pointer, so a read never meets a write to the same entry.
  lkv_ram #(
    .Width (RankW),
    .Depth (MaxEntries),
    .AddrW (IdxW)
  ) u_rank_ram (
    .clk_i   (clk_i),
    .we_i    (rank_we),
    .waddr_i (proc_idx_q),
    .wdata_i (rank_wdata),
    .re_i    (scan_issue),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (rank_rdata)
  );

  lkv_scan #(
    .IdxW  (IdxW),
    .RankW (RankW)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clear_i      (accept),
    .proc_vld_i   (proc_vld_q),
    .proc_idx_i   (proc_idx_q),
    .entry_vld_i  (valid_q[proc_idx_q]),
    .entry_key_i  (kv_rdata[KvW-1:VAL_W]),
    .entry_val_i  (kv_rdata[VAL_W-1:0]),
    .entry_rank_i (rank_rdata),
    .req_key_i    (req_key_q),
    .pend_i       (pend_q),
    .pend_slot_i  (pend_slot_q),
    .pend_rank_i  (pend_rank_q),
    .rank_we_o    (rank_we),
    .rank_wdata_o (rank_wdata),
    .flags_o      (flags),
    .found_idx_o  (found_idx),
    .found_rank_o (found_rank),
    .found_val_o  (found_val),
    .lru_idx_o    (lru_idx),
    .free_idx_o   (free_idx)
  );

  // Request sequencer: scan, then decide, write back and report.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      proc_vld_q  <= 1'b0;
      proc_idx_q  <= '0;
      cap_q       <= CAP_RESET;
      valid_q     <= '0;
      fill_q      <= '0;
      pend_q      <= '0;
      pend_slot_q <= '0;
      pend_rank_q <= '0;
      done_q      <= 1'b0;
      hit_q       <= 1'b0;
      ev_q        <= 1'b0;
      rdv_q       <= MISS_VALUE;
      req_cmd_q   <= CMD_GET;
      req_key_q   <= '0;
      req_val_q   <= '0;
    end else begin
      done_q     <= 1'b0;
      proc_vld_q <= scan_issue;
      proc_idx_q <= cnt_q[IdxW-1:0];
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            req_cmd_q <= lkv_cmd_e'(command_i);
            req_key_q <= $unsigned(lookup_key_i);
            req_val_q <= store_value_i;
            cnt_q     <= '0;
            state_q   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (scan_last) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          done_q  <= 1'b1;
          hit_q   <= flags.found;
          ev_q    <= evict_d;
          rdv_q   <= (!is_put && flags.found) ? {1'b0, found_val} : MISS_VALUE;
          state_q <= ST_IDLE;
          if (insert_d) begin
            valid_q[ins_slot_d] <= 1'b1;
            fill_q              <= fill_q + 1'b1;
          end
          // The age update is deferred to the next scan, which reads every
          // rank anyway.
          if (flags.found) begin
            pend_q.vld     <= 1'b1;
            pend_q.age_all <= 1'b0;
            pend_slot_q    <= found_idx;
            pend_rank_q    <= found_rank;
          end else if (evict_d || insert_d) begin
            pend_q.vld     <= 1'b1;
            pend_q.age_all <= 1'b1;
            pend_slot_q    <= ins_slot_d;
          end else begin
            pend_q.vld <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o       = done_q;
  assign hit_o        = hit_q;
  assign evicted_o    = ev_q;
  assign read_value_o = $signed(rdv_q);

`ifndef ASSERT_OFF
  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held longer than one cycle");

  a_done_after_finish : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_FINISH))
    else $error("result strobe without a finished request");

  a_fill_matches_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == 32'(fill_q))
    else $error("fill count disagrees with valid entries");

  a_evict_not_hit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(evicted_o && hit_o))
    else $error("eviction reported on a hit");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted request did not raise busy");
`endif

endmodule

/* dv/lru_key_value_cache_checker.sv */
`timescale 1ns / 1ps
// Result checker for the LRU key-value cache: tracks the cache contents from the
// request and capacity channels and compares every result strobe with its prediction.
// Depends on lkv_pkg.
module lru_key_value_cache_checker
  import lkv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic             command_i,
  input  logic [KEY_W-1:0] lookup_key_i,
  input  logic [VAL_W-1:0] store_value_i,
  input  logic             done_i,
  input  logic             hit_i,
  input  logic [31:0]      read_value_i,
  input  logic             evicted_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CAP_W-1:0] cfg_data_i,
  output int               error_count_o,
  output int               pending_o
);

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
  } cache_reply_t;

  logic [KEY_W-1:0] held_key   [LKV_MAX_ENTRIES];
  logic [VAL_W-1:0] held_value [LKV_MAX_ENTRIES];
  logic             held_valid [LKV_MAX_ENTRIES];
  logic [3:0]       held_rank  [LKV_MAX_ENTRIES];
  logic [CAP_W-1:0] held_count;
  logic [CAP_W-1:0] capacity_reg;

  cache_reply_t awaited_replies[$];
  cache_reply_t oldest_reply;
  int           mismatches  = 0;
  int           outstanding = 0;

  assign error_count_o = mismatches;
  assign pending_o     = outstanding;

  // A capacity of zero acts as one; anything above the entry count saturates.
  function automatic int usable_ways();
    int ways;
    ways = int'(capacity_reg);
    if (ways == 0) ways = 1;
    if (ways > int'(LKV_MAX_ENTRIES)) ways = int'(LKV_MAX_ENTRIES);
    return ways;
  endfunction

  function automatic void make_newest(int way);
    logic [3:0] old_rank;
    old_rank = held_rank[way];
    for (int i = 0; i < int'(LKV_MAX_ENTRIES); i++) begin
      if (held_valid[i] && i != way && held_rank[i] < old_rank) held_rank[i]++;
    end
    held_rank[way] = '0;
  endfunction

  function automatic cache_reply_t serve_request(lkv_cmd_e cmd, logic [KEY_W-1:0] key,
                                                 logic [VAL_W-1:0] value);
    cache_reply_t reply;
    int           way;
    logic [3:0]   oldest;
    reply.hit        = 1'b0;
    reply.read_value = MISS_VALUE;
    reply.evicted    = 1'b0;
    way              = -1;
    for (int i = 0; i < int'(LKV_MAX_ENTRIES); i++) begin
      if (held_valid[i] && held_key[i] == key) begin
        way = i;
        break;
      end
    end
    if (way >= 0) begin
      reply.hit = 1'b1;
      if (cmd == CMD_GET) reply.read_value = {1'b0, held_value[way]};
      else held_value[way] = value;
      make_newest(way);
    end else if (cmd == CMD_PUT) begin
      if (int'(held_count) >= usable_ways()) begin
        oldest = '0;
        for (int i = 0; i < int'(LKV_MAX_ENTRIES); i++) begin
          if (held_valid[i] && (way < 0 || held_rank[i] > oldest)) begin
            way    = i;
            oldest = held_rank[i];
          end
        end
        if (way >= 0) reply.evicted = 1'b1;
      end
      if (way < 0) begin
        for (int i = 0; i < int'(LKV_MAX_ENTRIES); i++) begin
          if (!held_valid[i]) begin
            way = i;
            break;
          end
        end
        if (way >= 0) begin
          held_valid[way] = 1'b1;
          held_rank[way]  = held_count[3:0];
          held_count++;
        end
      end
      if (way >= 0) begin
        held_key[way]   = key;
        held_value[way] = value;
        make_newest(way);
      end
    end
    return reply;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(LKV_MAX_ENTRIES); i++) begin
        held_valid[i] = 1'b0;
        held_rank[i]  = '0;
      end
      held_count   = '0;
      capacity_reg = CAP_RESET;
      awaited_replies.delete();
      outstanding  = 0;
    end else begin
      if (done_i) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: result with no request outstanding (hit %0b, value %h, evicted %0b)",
                   $time, hit_i, read_value_i, evicted_i);
          mismatches++;
        end else begin
          oldest_reply = awaited_replies.pop_front();
          if (hit_i !== oldest_reply.hit) begin
            $display("%0t: hit expected %0b, got %0b", $time, oldest_reply.hit, hit_i);
            mismatches++;
          end
          if (read_value_i !== oldest_reply.read_value) begin
            $display("%0t: read_value expected %h, got %h", $time,
                     oldest_reply.read_value, read_value_i);
            mismatches++;
          end
          if (evicted_i !== oldest_reply.evicted) begin
            $display("%0t: evicted expected %0b, got %0b", $time,
                     oldest_reply.evicted, evicted_i);
            mismatches++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) capacity_reg = cfg_data_i;
      if (start_i && !busy_i) begin
        awaited_replies.push_back(serve_request(lkv_cmd_e'(command_i), lookup_key_i,
                                                store_value_i));
      end
      outstanding = awaited_replies.size();
    end
  end

endmodule

/* dv/lru_key_value_cache_test.sv */
`timescale 1ns / 1ps
// Top of the LRU key-value cache testbench: clock, reset, request and capacity stimulus,
// and the final verdict. Depends on lkv_pkg, lru_key_value_cache and the checker module.
module lru_key_value_cache_test;
  import lkv_pkg::*;

  // The slowest legal run is roughly 900 requests plus random idle gaps between some of
  // them; the limit leaves a wide margin above that.
  localparam int CYCLE_LIMIT  = 200000;
  // Once the last result has come, the test waits DRAIN_CYCLES longer before the verdict.
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 80;
  localparam int POOL_SIZE    = 24;
  localparam int PHASE_COUNT  = 11;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  lkv_cmd_e         command;
  logic [KEY_W-1:0] lookup_key;
  logic [VAL_W-1:0] store_value;
  logic             done;
  logic             hit;
  logic [31:0]      read_value;
  logic             evicted;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data;
  int               errors;
  int               pending;
  int               cycle_count = 0;
  int               item_no     = 0;
  int               pool_span   = POOL_SIZE;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  // Capacity settings visited by the random phases. They include zero (acts as one),
  // the all-ones code (saturates at the entry count), and drops below the current fill.
  logic [CAP_W-1:0] phase_caps [PHASE_COUNT] = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd16, 5'd8,
                                                  5'd17, 5'd2, 5'd24, 5'd5, 5'd16};

  always #1 clk = ~clk;

  // Timeout guard: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("lru_key_value_cache_test: errors");
      $finish;
    end
  end

  lru_key_value_cache uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start        (start),
    .busy         (busy),
    .command_i    (command),
    .lookup_key_i (lookup_key),
    .store_value_i(store_value),
    .done_o       (done),
    .hit_o        (hit),
    .read_value_o (read_value),
    .evicted_o    (evicted),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  lru_key_value_cache_checker result_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_i       (busy),
    .command_i    (command),
    .lookup_key_i (lookup_key),
    .store_value_i(store_value),
    .done_i       (done),
    .hit_i        (hit),
    .read_value_i (read_value),
    .evicted_i    (evicted),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .error_count_o(errors),
    .pending_o    (pending)
  );

  // Presents one request, starting at a falling edge, and returns at the falling edge
  // after it was taken. Start is left high so that a following request can go straight
  // on; whoever stops issuing requests lowers it. Now and then the sender idles first,
  // except in a quiet stretch in the middle of the run where requests go back to back.
  task automatic send_request(lkv_cmd_e cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] value);
    if (!(item_no >= 300 && item_no < 460) && $urandom_range(99, 0) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(25, 1)) @(negedge clk);
    end
    start       <= 1'b1;
    command     <= cmd;
    lookup_key  <= key;
    store_value <= value;
    do @(posedge clk); while (busy);
    item_no++;
    @(negedge clk);
  endtask

  // Mostly keys from a small pool sized to the capacity, so hits, updates and evictions
  // are frequent; the rest are fresh random keys that almost always miss.
  task automatic random_request();
    lkv_cmd_e         cmd;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    cmd   = $urandom_range(1, 0) ? CMD_PUT : CMD_GET;
    key   = ($urandom_range(99, 0) < 85) ? key_pool[$urandom_range(pool_span - 1, 0)]
                                         : $urandom;
    value = VAL_W'($urandom);
    send_request(cmd, key, value);
  endtask

  // The capacity is changed only with nothing in flight: every request has given its
  // result and the block has dropped busy.
  task automatic write_capacity(logic [CAP_W-1:0] cap);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int ways;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    command     <= CMD_GET;
    lookup_key  <= '0;
    store_value <= '0;
    cfg_valid   <= 1'b0;
    cfg_data    <= '0;

    // The first pool keys are the extremes of the key range; the rest are random.
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h7FFF_FFFF;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at full capacity: a get on the empty store, puts and gets on the
    // extreme keys and values, an update of a held key, and a get that misses.
    write_capacity(5'd16);
    send_request(CMD_GET, 32'h0000_0000, 31'h0000_0000);
    send_request(CMD_PUT, 32'h8000_0000, 31'h7FFF_FFFF);
    send_request(CMD_GET, 32'h8000_0000, 31'h0000_0000);
    send_request(CMD_PUT, 32'h7FFF_FFFF, 31'h0000_0000);
    send_request(CMD_PUT, 32'hFFFF_FFFF, 31'h0000_0001);
    send_request(CMD_PUT, 32'h0000_0000, 31'h5555_5555);
    send_request(CMD_GET, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
    send_request(CMD_PUT, 32'h0000_0000, 31'h2AAA_AAAA);
    send_request(CMD_GET, 32'h0000_0000, 31'h0000_0000);
    send_request(CMD_GET, 32'h1234_5678, 31'h0000_0000);

    // Capacity lowered below the current fill: held entries stay, and a new key
    // replaces the least recent one while the fill stays the same.
    write_capacity(5'd2);
    send_request(CMD_PUT, 32'h0000_0011, 31'h0000_0003);
    send_request(CMD_GET, 32'h7FFF_FFFF, 31'h0000_0000);
    send_request(CMD_PUT, 32'h8000_0000, 31'h0000_0044);
    send_request(CMD_GET, 32'h0000_0011, 31'h0000_0000);

    // A capacity of zero behaves as one.
    write_capacity(5'd0);
    send_request(CMD_PUT, 32'h0000_0022, 31'h0000_0022);
    send_request(CMD_GET, 32'h0000_0022, 31'h0000_0000);
    send_request(CMD_GET, 32'h0000_0011, 31'h0000_0000);

    // A capacity above the entry count saturates, so the store grows again.
    write_capacity(5'd31);
    send_request(CMD_PUT, 32'h0000_0033, 31'h0000_0033);
    send_request(CMD_PUT, 32'h0000_0044, 31'h7FFF_FFFE);
    send_request(CMD_GET, 32'h0000_0033, 31'h0000_0000);

    // Random phases, each at its own capacity, with a key pool a little larger than
    // the number of usable entries.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      write_capacity(phase_caps[p]);
      ways = int'(phase_caps[p]);
      if (ways == 0) ways = 1;
      if (ways > int'(LKV_MAX_ENTRIES)) ways = int'(LKV_MAX_ENTRIES);
      pool_span = (ways + 4 > POOL_SIZE) ? POOL_SIZE : ways + 4;
      repeat (PHASE_ITEMS) random_request();
    end

    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("lru_key_value_cache_test: clean");
    end else begin
      $display("lru_key_value_cache_test: errors");
    end
    $finish;
  end

endmodule
